// File: rtl/msc_pkg.sv
// shared types, constants and register codes for the motor sensor conversion block
// no dependencies
package msc_pkg;

  localparam int ADC_BITS_DEF    = 12;
  localparam int UPDATE_MS_DEF   = 10;

  localparam int IN_CODE_W = 12;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  localparam int LOG_W     = 20;
  localparam int M_W       = 31;
  localparam int L_W       = 21;
  localparam int D_W       = 23;
  localparam int TERM_W    = 30;
  localparam int DEN_W     = 48;
  localparam int DVD_W     = 60;
  localparam int DVS_W     = 47;
  localparam int QUO_W     = 17;
  localparam int DSH_W     = DVS_W + QUO_W - 1;
  localparam int LOG_STEPS = 16;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [4:0]  LOG_NORM  = 5'd30;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic signed [15:0] TEMP_LOW  = -16'sd2732;
  localparam logic signed [15:0] TEMP_HIGH = 16'sd20000;
  localparam logic [15:0] SAT16     = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_FIXED_OHM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_OHM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_CK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_MV      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHUNT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_EN    = 3'd7;

  typedef struct packed {
    logic [19:0] ntc_fixed_ohm;
    logic [19:0] ntc_nominal_ohm;
    logic [13:0] ntc_beta_kelvin;
    logic [15:0] ntc_nominal_centikelvin;
    logic [12:0] reference_mv;
    logic [19:0] shunt_gain_milliohm;
    logic [15:0] divider_ratio_q8;
    logic        motor_ntc_enabled;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PREP1, OP_PREP2, OP_LOG_INIT, OP_LOG_STEP, OP_LOG_ACC,
    OP_TERM, OP_DEN, OP_TDIV_INIT, OP_CDIV_INIT, OP_DIV_STEP, OP_TSTORE,
    OP_CUR1, OP_CUR2, OP_CSTORE, OP_SUP1, OP_SUP2, OP_SSTORE, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_PREP1, S_PREP2, S_LOG_INIT, S_LOG_STEP, S_LOG_ACC,
    S_TERM, S_DEN, S_TDIV_INIT, S_DIV_STEP, S_TSTORE, S_CUR1, S_CUR2,
    S_CDIV_INIT, S_CSTORE, S_SUP1, S_SUP2, S_SSTORE, S_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
    logic       sensor;
  } cmd_t;

  typedef struct packed {
    logic fresh;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/msc_regs.sv
// configuration register file, write only
// depends on msc_pkg
module msc_regs import msc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ntc_fixed_ohm           <= 20'd10000;
      cfg.ntc_nominal_ohm         <= 20'd10000;
      cfg.ntc_beta_kelvin         <= 14'd3950;
      cfg.ntc_nominal_centikelvin <= 16'd29815;
      cfg.reference_mv            <= 13'd3300;
      cfg.shunt_gain_milliohm     <= 20'd1000;
      cfg.divider_ratio_q8        <= 16'd2816;
      cfg.motor_ntc_enabled       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIXED_OHM:   cfg.ntc_fixed_ohm           <= cfg_data;
        REG_NOMINAL_OHM: cfg.ntc_nominal_ohm         <= cfg_data;
        REG_BETA:        cfg.ntc_beta_kelvin         <= cfg_data[13:0];
        REG_NOMINAL_CK:  cfg.ntc_nominal_centikelvin <= cfg_data[15:0];
        REG_REF_MV:      cfg.reference_mv            <= cfg_data[12:0];
        REG_SHUNT:       cfg.shunt_gain_milliohm     <= cfg_data;
        REG_DIVIDER:     cfg.divider_ratio_q8        <= cfg_data[15:0];
        REG_MOTOR_EN:    cfg.motor_ntc_enabled       <= cfg_data[0];
      endcase
    end
  end

endmodule

// File: rtl/msc_ctrl.sv
// sequencer for one conversion: log steps, divide steps and stores
// depends on msc_pkg
module msc_ctrl import msc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] sel, sel_next;
  logic       sensor, sensor_next;
  logic       cur_phase, cur_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sel       <= '0;
      sensor    <= 1'b0;
      cur_phase <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      sel       <= sel_next;
      sensor    <= sensor_next;
      cur_phase <= cur_phase_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_CHECK;
      S_CHECK:     state_next = sts.fresh ? S_PREP1 : S_OUT;
      S_PREP1:     state_next = S_PREP2;
      S_PREP2:     state_next = S_LOG_INIT;
      S_LOG_INIT:  state_next = S_LOG_STEP;
      S_LOG_STEP:  if (cnt == 5'(LOG_STEPS - 1)) state_next = S_LOG_ACC;
      S_LOG_ACC:   state_next = (sel == 2'd3) ? S_TERM : S_LOG_INIT;
      S_TERM:      state_next = S_DEN;
      S_DEN:       state_next = S_TDIV_INIT;
      S_TDIV_INIT: state_next = S_DIV_STEP;
      S_DIV_STEP: begin
        if (cnt == 5'(DIV_STEPS - 1)) state_next = cur_phase ? S_CSTORE : S_TSTORE;
      end
      S_TSTORE:    state_next = sensor ? S_CUR1 : S_LOG_INIT;
      S_CUR1:      state_next = S_CUR2;
      S_CUR2:      state_next = S_CDIV_INIT;
      S_CDIV_INIT: state_next = S_DIV_STEP;
      S_CSTORE:    state_next = S_SUP1;
      S_SUP1:      state_next = S_SUP2;
      S_SUP2:      state_next = S_SSTORE;
      S_SSTORE:    state_next = S_OUT;
      S_OUT:       if (sts.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_next       = '0;
    sel_next       = sel;
    sensor_next    = sensor;
    cur_phase_next = cur_phase;
    if (state == S_LOG_STEP && cnt != 5'(LOG_STEPS - 1)) cnt_next = cnt + 5'd1;
    if (state == S_DIV_STEP && cnt != 5'(DIV_STEPS - 1)) cnt_next = cnt + 5'd1;
    if (state == S_IDLE) begin
      sel_next       = '0;
      sensor_next    = 1'b0;
      cur_phase_next = 1'b0;
    end
    if (state == S_LOG_ACC) sel_next = sel + 2'd1;
    if (state == S_TSTORE) sensor_next = 1'b1;
    if (state == S_CUR1) cur_phase_next = 1'b1;
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.sel    = sel;
    cmd.sensor = sensor;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_PREP1:     cmd.op = OP_PREP1;
      S_PREP2:     cmd.op = OP_PREP2;
      S_LOG_INIT:  cmd.op = OP_LOG_INIT;
      S_LOG_STEP:  cmd.op = OP_LOG_STEP;
      S_LOG_ACC:   cmd.op = OP_LOG_ACC;
      S_TERM:      cmd.op = OP_TERM;
      S_DEN:       cmd.op = OP_DEN;
      S_TDIV_INIT: cmd.op = OP_TDIV_INIT;
      S_DIV_STEP:  cmd.op = OP_DIV_STEP;
      S_TSTORE:    cmd.op = OP_TSTORE;
      S_CUR1:      cmd.op = OP_CUR1;
      S_CUR2:      cmd.op = OP_CUR2;
      S_CDIV_INIT: cmd.op = OP_CDIV_INIT;
      S_CSTORE:    cmd.op = OP_CSTORE;
      S_SUP1:      cmd.op = OP_SUP1;
      S_SUP2:      cmd.op = OP_SUP2;
      S_SSTORE:    cmd.op = OP_SSTORE;
      S_OUT:       if (sts.out_free) cmd.op = OP_OUT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/msc_dp.sv
// datapath: log2 squaring unit, restoring divider, stores and output register
// depends on msc_pkg
module msc_dp import msc_pkg::*; #(
  parameter int ADC_BITS         = ADC_BITS_DEF,
  parameter int UPDATE_PERIOD_MS = UPDATE_MS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  cfg_t                 cfg,
  input  logic [31:0]          now_ms,
  input  logic [IN_CODE_W-1:0] bridge_ntc_code,
  input  logic [IN_CODE_W-1:0] motor_ntc_code,
  input  logic [IN_CODE_W-1:0] current_code,
  input  logic [IN_CODE_W-1:0] supply_code,
  input  logic                 driver_asleep,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          bridge_temp_decic,
  output logic [15:0]          motor_temp_decic,
  output logic [15:0]          motor_current_ma,
  output logic [15:0]          supply_mv,
  output logic                 refreshed
);

  localparam int CODE_W = ADC_BITS;
  localparam int FS_W   = ADC_BITS + 1;
  localparam int EXT_W  = (IN_CODE_W > FS_W) ? IN_CODE_W : FS_W;
  localparam int CP_W   = CODE_W + 13;
  localparam int CN_W   = CP_W + 10;
  localparam int SV_W   = CP_W + 16;
  localparam logic [FS_W-1:0] FSV = FS_W'(1) << ADC_BITS;

  function automatic logic [CODE_W-1:0] clamp(input logic [IN_CODE_W-1:0] c);
    logic [EXT_W-1:0] e;
    e = EXT_W'(c);
    clamp = (e >= EXT_W'(FSV)) ? CODE_W'(FSV - FS_W'(1)) : CODE_W'(e);
  endfunction

  // latched item
  logic [31:0]       now_r, last_ms;
  logic [CODE_W-1:0] b_code, m_code, i_code, s_code;
  logic              asleep, fresh;

  // stores
  logic [15:0] bridge_store, motor_store, current_store, supply_store;

  // arithmetic registers
  logic [29:0]              tb;
  logic [20:0]              b100;
  logic [DVD_W-1:0]         num2;
  logic [4:0]               lg_n;
  logic [15:0]              lg_frac;
  logic [M_W-1:0]           lg_m;
  logic signed [D_W-1:0]    dacc;
  logic signed [TERM_W-1:0] term;
  logic signed [DEN_W-1:0]  den;
  logic                     den_bad, ovf;
  logic [DVD_W-1:0]         rem;
  logic [DSH_W-1:0]         dsh;
  logic [QUO_W-1:0]         quo;
  logic [CP_W-1:0]          cp;
  logic [CN_W-1:0]          cnum;
  logic [SV_W-1:0]          sval;

  // combinational helpers
  logic [CODE_W-1:0]        code;
  logic [LOG_W-1:0]         lx;
  logic [4:0]               lead;
  logic [2*M_W-1:0]         sq_full;
  logic [M_W:0]             sq;
  logic signed [D_W-1:0]    lval;
  logic signed [39:0]       tprod, tadj;
  logic signed [46:0]       tt;
  logic [DVD_W-1:0]         n_sel;
  logic [DVS_W-1:0]         d_sel;
  logic                     div_ge;
  logic [QUO_W:0]           half;
  logic signed [18:0]       tres;
  logic [15:0]              tval;
  logic                     zero_res;
  logic [SV_W:0]            sround;

  assign code = cmd.sensor ? m_code : b_code;

  always_comb begin
    case (cmd.sel)
      2'd0:    lx = cfg.ntc_fixed_ohm;
      2'd1:    lx = LOG_W'(code);
      2'd2:    lx = LOG_W'(FSV - FS_W'(code));
      default: lx = cfg.ntc_nominal_ohm;
    endcase
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < LOG_W; i++) begin
      if (lx[i]) lead = 5'(i);
    end
  end

  assign sq_full = lg_m * lg_m;
  assign sq      = sq_full[2*M_W-1:M_W-1];
  assign lval    = $signed(D_W'({lg_n, lg_frac}));

  assign tprod = dacc * $signed({1'b0, LN2_Q16});
  assign tadj  = tprod[39] ? tprod + 40'sd255 : tprod;
  assign tt    = term * $signed({1'b0, cfg.ntc_nominal_centikelvin});

  always_comb begin
    if (cmd.op == OP_CDIV_INIT) begin
      n_sel = DVD_W'({cnum, 1'b0}) + (DVD_W'(cfg.shunt_gain_milliohm) << ADC_BITS);
      d_sel = DVS_W'(cfg.shunt_gain_milliohm) << (ADC_BITS + 1);
    end else begin
      n_sel = num2;
      d_sel = DVS_W'(den);
    end
  end

  assign div_ge = {{(DSH_W - DVD_W){1'b0}}, rem} >= dsh;

  assign zero_res = (code == '0) || (cfg.ntc_fixed_ohm == '0) ||
                    (cfg.ntc_nominal_ohm == '0) || (cfg.ntc_beta_kelvin == '0) ||
                    (cfg.ntc_nominal_centikelvin == '0);
  assign half = ({1'b0, quo} + (QUO_W+1)'(2)) >> 1;
  assign tres = $signed({1'b0, half}) - 19'sd2732;

  always_comb begin
    if (zero_res) tval = TEMP_LOW;
    else if (den_bad || ovf || tres > 19'sd20000) tval = TEMP_HIGH;
    else if (tres < -19'sd2732) tval = TEMP_LOW;
    else tval = tres[15:0];
  end

  assign sround = ({1'b0, sval} + ((SV_W+1)'(1) << (ADC_BITS + 7))) >> (ADC_BITS + 8);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        now_r  <= now_ms;
        b_code <= clamp(bridge_ntc_code);
        m_code <= clamp(motor_ntc_code);
        i_code <= clamp(current_code);
        s_code <= clamp(supply_code);
        asleep <= driver_asleep;
      end
      OP_PREP1: begin
        tb   <= cfg.ntc_nominal_centikelvin * cfg.ntc_beta_kelvin;
        b100 <= 21'(cfg.ntc_beta_kelvin * 7'd100);
      end
      OP_PREP2: num2 <= DVD_W'({35'(tb * 5'd20), 24'b0});
      OP_LOG_INIT: begin
        lg_n    <= lead;
        lg_frac <= '0;
        lg_m    <= M_W'(lx) << (LOG_NORM - lead);
      end
      OP_LOG_STEP: begin
        lg_m    <= sq[M_W] ? sq[M_W:1] : sq[M_W-1:0];
        lg_frac <= {lg_frac[14:0], sq[M_W]};
      end
      OP_LOG_ACC: begin
        case (cmd.sel)
          2'd0:    dacc <= lval;
          2'd1:    dacc <= dacc + lval;
          default: dacc <= dacc - lval;
        endcase
      end
      OP_TERM: term <= TERM_W'(tadj >>> 8);
      OP_DEN:  den <= $signed({3'b0, b100, 24'b0}) + $signed({tt[46], tt});
      OP_TDIV_INIT, OP_CDIV_INIT: begin
        den_bad <= (den <= 0);
        ovf     <= {{(DVS_W - (DVD_W - QUO_W)){1'b0}}, n_sel[DVD_W-1:QUO_W]} >= d_sel;
        rem     <= n_sel;
        dsh     <= {d_sel, {(QUO_W-1){1'b0}}};
        quo     <= '0;
      end
      OP_DIV_STEP: begin
        if (div_ge) rem <= rem - DVD_W'(dsh);
        quo <= {quo[QUO_W-2:0], div_ge};
        dsh <= dsh >> 1;
      end
      OP_CUR1: cp <= i_code * cfg.reference_mv;
      OP_CUR2: cnum <= cp * 10'd1000;
      OP_SUP1: cp <= s_code * cfg.reference_mv;
      OP_SUP2: sval <= cp * cfg.divider_ratio_q8;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ms       <= '0;
      bridge_store  <= '0;
      motor_store   <= '0;
      current_store <= '0;
      supply_store  <= '0;
      fresh         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) fresh <= (now_ms - last_ms) >= 32'(UPDATE_PERIOD_MS);
      if (cmd.op == OP_TSTORE) begin
        if (cmd.sensor) motor_store <= tval;
        else bridge_store <= tval;
      end
      if (cmd.op == OP_CSTORE) begin
        current_store <= (cfg.shunt_gain_milliohm == '0 || ovf || quo[QUO_W-1]) ?
                         SAT16 : quo[15:0];
      end
      if (cmd.op == OP_SSTORE) begin
        supply_store <= (sround > (SV_W+1)'(SAT16)) ? SAT16 : sround[15:0];
        last_ms      <= now_r;
      end
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      bridge_temp_decic <= bridge_store;
      motor_temp_decic  <= cfg.motor_ntc_enabled ? motor_store : 16'd0;
      motor_current_ma  <= asleep ? 16'd0 : current_store;
      supply_mv         <= supply_store;
      refreshed         <= fresh;
    end
  end

  assign sts.fresh    = fresh;
  assign sts.out_free = !out_valid || out_ready;

endmodule

// File: rtl/motor_sensor_conversion_top.sv
// Motor sensor conversion: converts raw thermistor, current and supply ADC
// words into temperatures, motor current and supply voltage.
// Input channel s_axis: one word per sensor frame (tick, four codes, sleep pin).
// Output channel m_axis: one word per input word with the stored results;
// tuser flags a word whose frame started a new conversion.
// cfg_we/cfg_index/cfg_data write the eight settings; the user must write them
// only while idle, as the block itself does not enforce it. A frame within the
// update period since the last conversion is answered from the stored results.
// For a converting frame, each thermistor gets four 16-step log2 passes on the
// shared squaring multiplier and a 17-step restoring divide, then the current
// gets a 17-step divide. One frame is worked at a time; the next is taken once
// the result sits in the output register, so it is accepted while that result
// waits. If m_axis_tready stays low the result holds and the block stops before
// loading the next one. Synchronous reset restores the default settings and
// clears the stored results and the last update tick.
// depends on msc_pkg, msc_regs, msc_ctrl, msc_dp
module motor_sensor_conversion_top import msc_pkg::*; #(
  parameter int ADC_BITS         = ADC_BITS_DEF,
  parameter int UPDATE_PERIOD_MS = UPDATE_MS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // now_ms, bridge_ntc_code, motor_ntc_code, current_code, supply_code, driver_asleep
  input  logic [87:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // bridge_temp_decic, motor_temp_decic, motor_current_ma, supply_mv
  output logic [63:0]          m_axis_tdata,
  // refreshed
  output logic [0:0]           m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  msc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msc_dp #(
    .ADC_BITS         (ADC_BITS),
    .UPDATE_PERIOD_MS (UPDATE_PERIOD_MS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg),
    .now_ms            (s_axis_tdata[31:0]),
    .bridge_ntc_code   (s_axis_tdata[43:32]),
    .motor_ntc_code    (s_axis_tdata[55:44]),
    .current_code      (s_axis_tdata[67:56]),
    .supply_code       (s_axis_tdata[79:68]),
    .driver_asleep     (s_axis_tdata[80]),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .bridge_temp_decic (m_axis_tdata[15:0]),
    .motor_temp_decic  (m_axis_tdata[31:16]),
    .motor_current_ma  (m_axis_tdata[47:32]),
    .supply_mv         (m_axis_tdata[63:48]),
    .refreshed         (m_axis_tuser[0])
  );

endmodule

// File: tb/tb.sv
// testbench for motor_sensor_conversion_top: streams sensor frames, predicts
// the stored temperatures, current and supply, and compares every output word
// depends on msc_pkg and motor_sensor_conversion_top
`timescale 1ns / 1ps
module tb;
  import msc_pkg::*;

  localparam int FS = 1 << ADC_BITS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  motor_sensor_conversion_top dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  typedef struct {
    logic [31:0] now;
    logic [11:0] bc, mc, ic, sc;
    logic asleep;
  } frame_t;

  typedef struct {
    logic [15:0] bt, mt, cur, sup;
    logic fresh;
  } reading_t;

  // predictor state
  longint unsigned r_fix, r_nom, beta, t0, vref, shunt, divr, men;
  logic [31:0] last_ms;
  logic [15:0] bt_st, mt_st, cur_st, sup_st;

  reading_t readings_q[$];
  int errors = 0, n_words = 0, n_fresh = 0;
  bit rdy_random = 1'b1;

  function automatic longint log2q(longint unsigned x);
    int n;
    longint unsigned m, fr;
    n = 63;
    fr = 0;
    while (n > 0 && x[n] == 1'b0) n--;
    if (n <= 30) m = x << (30 - n);
    else m = x >> (n - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        fr |= 64'd1 << (15 - i);
      end
    end
    return longint'((64'(n) << 16) | fr);
  endfunction

  function automatic logic [15:0] temp_of(longint unsigned code);
    longint d, term, den, num, t2, res;
    if (code == 0 || r_fix == 0 || r_nom == 0 || beta == 0 || t0 == 0)
      return 16'(-2732);
    d = log2q(r_fix) + log2q(code) - log2q(FS - code) - log2q(r_nom);
    term = (d * 45426) / 256;
    den = 100 * longint'(beta) * 16777216 + term * longint'(t0);
    if (den <= 0) return 16'd20000;
    num = 10 * longint'(t0) * longint'(beta) * 16777216;
    t2 = (2 * num) / den;
    res = (t2 + 2) / 2 - 2732;
    if (res < -2732) res = -2732;
    if (res > 20000) res = 20000;
    return 16'(res);
  endfunction

  function automatic logic [15:0] round_sat(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 65535) ? 16'hFFFF : 16'(q);
  endfunction

  function automatic reading_t predict_reading(frame_t f);
    reading_t r;
    r.fresh = (f.now - last_ms) >= 32'(UPDATE_MS_DEF);
    if (r.fresh) begin
      bt_st = temp_of(f.bc);
      mt_st = temp_of(f.mc);
      cur_st = (shunt == 0) ? 16'hFFFF
             : round_sat(longint'(f.ic) * vref * 1000, FS * shunt);
      sup_st = round_sat(longint'(f.sc) * vref * divr, FS * 256);
      last_ms = f.now;
    end
    r.bt = bt_st;
    r.mt = men ? mt_st : 16'd0;
    r.cur = f.asleep ? 16'd0 : cur_st;
    r.sup = sup_st;
    return r;
  endfunction

  task automatic set_defaults();
    r_fix = 10000; r_nom = 10000; beta = 3950; t0 = 29815;
    vref = 3300; shunt = 1000; divr = 2816; men = 1;
    last_ms = '0; bt_st = '0; mt_st = '0; cur_st = '0; sup_st = '0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_FIXED_OHM:   r_fix = val;
      REG_NOMINAL_OHM: r_nom = val;
      REG_BETA:        beta = val[13:0];
      REG_NOMINAL_CK:  t0 = val[15:0];
      REG_REF_MV:      vref = val[12:0];
      REG_SHUNT:       shunt = val;
      REG_DIVIDER:     divr = val[15:0];
      default:         men = val[0];
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (readings_q.size() != 0) @(negedge clk);
    repeat (260) @(negedge clk);
  endtask

  task automatic send_frame(frame_t f, bit gaps);
    if (gaps && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_axis_tdata <= {f.asleep, f.sc, f.ic, f.mc, f.bc, f.now};
    s_axis_tvalid <= 1'b1;
    readings_q.push_back(predict_reading(f));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver with random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (rdy_random && $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reading_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_words++;
      if (readings_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = readings_q.pop_front();
        if (m_axis_tuser[0]) n_fresh++;
        if ({e.sup, e.cur, e.mt, e.bt, e.fresh} !== {m_axis_tdata, m_axis_tuser[0]}) begin
          $display("%0t: expected bt %0d mt %0d cur %0d sup %0d fresh %0b", $time,
                   $signed(e.bt), $signed(e.mt), e.cur, e.sup, e.fresh);
          $display("%0t: actual   bt %0d mt %0d cur %0d sup %0d fresh %0b", $time,
                   $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                   m_axis_tdata[47:32], m_axis_tdata[63:48], m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("motor_sensor_conversion_top: mismatch");
    $finish;
  end

  // directed rows: tick, bridge, motor, current, supply, asleep
  localparam int NDIR = 14;
  logic [31:0] dir_now[NDIR] = '{32'd0, 32'd5, 32'd10, 32'd20, 32'd30, 32'd40,
    32'd50, 32'd59, 32'd60, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd8, 32'd100, 32'd200};
  logic [11:0] dir_b[NDIR] = '{12'd100, 12'd0, 12'd0, 12'hFFF, 12'd2048, 12'd1,
    12'd3000, 12'd5, 12'd1234, 12'd4000, 12'd7, 12'd2500, 12'hFFF, 12'd0};
  logic [11:0] dir_m[NDIR] = '{12'd100, 12'hFFF, 12'd0, 12'd1, 12'd2048, 12'hFFF,
    12'd800, 12'd5, 12'd225, 12'd3, 12'd7, 12'd1500, 12'd0, 12'hFFF};
  logic [11:0] dir_i[NDIR] = '{12'd10, 12'd0, 12'd0, 12'hFFF, 12'd2048, 12'd1,
    12'd99, 12'd5, 12'd777, 12'hFFF, 12'd7, 12'd2000, 12'hFFF, 12'd0};
  logic [11:0] dir_s[NDIR] = '{12'd10, 12'd0, 12'd0, 12'hFFF, 12'd2048, 12'd1,
    12'd99, 12'd5, 12'd3000, 12'hFFF, 12'd7, 12'd1000, 12'hFFF, 12'd0};
  logic dir_sl[NDIR] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  // settings per phase: fix, nominal, beta, t0, ref, shunt, divider, motor_en
  localparam int NSET = 5;
  logic [19:0] set_tab[NSET][8] = '{
    '{20'd10000, 20'd10000, 20'd3950, 20'd29815, 20'd3300, 20'd1000, 20'd2816, 20'd0},
    '{20'd1, 20'd1000000, 20'd10000, 20'd50000, 20'd5000, 20'd1, 20'd65535, 20'd1},
    '{20'd1000000, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1000000, 20'd256, 20'd1},
    '{20'd0, 20'd4700, 20'd3435, 20'd29815, 20'd3300, 20'd0, 20'd3000, 20'd1},
    '{20'd47000, 20'd100000, 20'd4250, 20'd29815, 20'd3300, 20'd50, 20'd2816, 20'd1}};

  initial begin
    frame_t f;
    reading_t e;
    logic [31:0] tick;
    set_defaults();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < NDIR; i++) begin
      f.now = dir_now[i]; f.bc = dir_b[i]; f.mc = dir_m[i];
      f.ic = dir_i[i]; f.sc = dir_s[i]; f.asleep = dir_sl[i];
      send_frame(f, 1'b1);
      if (i == 0) begin
        e = readings_q[$];
        // first frame after reset is within the period: reports reset stores
        if (e.fresh || e.bt != 0 || e.sup != 0) begin
          $display("%0t: expected reset stores, predictor gave %h", $time, e.sup);
          errors++;
        end
      end
    end
    tick = 32'd300;
    for (int p = 0; p < NSET; p++) begin
      drain();
      for (int r = 0; r < 8; r++) write_reg(CFG_IDX_W'(r), set_tab[p][r]);
      cfg_we <= 1'b0;
      if (p == NSET - 1) rdy_random = 1'b0;
      for (int k = 0; k < 170; k++) begin
        case ($urandom_range(3))
          0: tick = tick + $urandom_range(9);
          1: tick = tick + 10;
          2: tick = tick + $urandom_range(11, 40);
          default: tick = $urandom;
        endcase
        f.now = tick;
        f.bc = (($urandom_range(7)) == 0) ? 12'($urandom_range(1) * 12'hFFF) : 12'($urandom);
        f.mc = 12'($urandom);
        f.ic = 12'($urandom);
        f.sc = 12'($urandom);
        f.asleep = 1'($urandom_range(1));
        send_frame(f, p != NSET - 1);
      end
    end
    drain();
    $display("%0d output words checked, %0d of them fresh conversions, %0d settings",
             n_words, n_fresh, NSET + 1);
    if (errors == 0) begin
      $display("motor_sensor_conversion_top: match");
    end else begin
      $display("motor_sensor_conversion_top: mismatch");
    end
    $finish;
  end

endmodule
